// File: sv/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority packet queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int ID_W     = 16;
    localparam int LEVEL_W  = 8;
    localparam int STATUS_W = 2;

    typedef enum logic {
        ACT_PUT = 1'b0,
        ACT_GET = 1'b1
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [LEVEL_W-1:0] level;
    } t_entry;

    // broadcast to every cell at once
    typedef struct packed {
        logic               put;
        logic               get;
        logic [ID_W-1:0]    id;
        logic [LEVEL_W-1:0] level;
    } t_cell_ctl;

endpackage

// File: sv/spq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for queue requests and their results.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [spq_pkg::ID_W-1:0]     packet_id;
    logic [spq_pkg::LEVEL_W-1:0]  priority_req;

    modport source (output valid, action, packet_id, priority_req, input ready);
    modport sink   (input valid, action, packet_id, priority_req, output ready);
endinterface

interface spq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::ID_W-1:0]     out_packet_id;
    logic [spq_pkg::LEVEL_W-1:0]  out_priority;

    modport source (output valid, status, out_packet_id, out_priority, input ready);
    modport sink   (input valid, status, out_packet_id, out_priority, output ready);
endinterface

// File: sv/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: compares its level with a new item and
// holds, loads the new item, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_keep,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_keep
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // entry stays ahead of the new item: equal levels keep arrival order
    assign o_keep  = i_occupied && (r_entry.level <= i_ctl.level);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.put) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry.id    = i_ctl.id;
                n_entry.level = i_ctl.level;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.get) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: sv/stable_priority_packet_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_packet_queue_unit
// Fixed-capacity packet queue sorted by ascending priority level.
// ----------------------------------------------------------------------------
// The queue takes one item per clock cycle while i_req.ready is high, returns
// its result in the cycle after acceptance, and completes each put or get in
// its accepting cycle because a row of CAPACITY cells compares the new level
// in every slot at once and each cell shifts from its neighbor in the same
// edge. The result register holds a result until it is taken, and a new item
// is accepted in the same cycle as the waiting result leaves. A put lands
// after all entries of lower or equal level; a put to a full queue returns
// status full, a get from an empty queue returns status empty, and neither
// changes the contents; slots need no reset, only occupancy and valid do.
// ----------------------------------------------------------------------------
module stable_priority_packet_queue_unit #(
    parameter int CAPACITY = spq_pkg::CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_req_if.sink       i_req,
    spq_rsp_if.source     o_rsp
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic [OCC_W-1:0]   r_occupancy;
    logic [OCC_W-1:0]   n_occupancy;
    logic               r_rsp_valid;
    logic [spq_pkg::STATUS_W-1:0] r_status;
    logic [spq_pkg::ID_W-1:0]     r_id;
    logic [spq_pkg::LEVEL_W-1:0]  r_level;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    spq_pkg::t_cell_ctl w_ctl;

    spq_pkg::t_entry    w_entry     [CAPACITY];
    spq_pkg::t_entry    w_left      [CAPACITY];
    spq_pkg::t_entry    w_right     [CAPACITY];
    logic               w_keep      [CAPACITY];
    logic               w_left_keep [CAPACITY];
    logic               w_occupied  [CAPACITY];

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_occupancy == OCC_W'(CAPACITY));
    assign w_empty     = (r_occupancy == '0);

    always_comb begin
        w_ctl.put   = w_accept && (i_req.action == spq_pkg::ACT_PUT) && !w_full;
        w_ctl.get   = w_accept && (i_req.action == spq_pkg::ACT_GET) && !w_empty;
        w_ctl.id    = i_req.packet_id;
        w_ctl.level = i_req.priority_req;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_occupied[gi] = (r_occupancy > OCC_W'(gi));

            if (gi == 0) begin : g_head
                // head cell: the new item goes here unless this entry stays
                assign w_left[gi].id    = w_ctl.id;
                assign w_left[gi].level = w_ctl.level;
                assign w_left_keep[gi]  = 1'b1;
            end else begin : g_body
                assign w_left[gi]      = w_entry[gi-1];
                assign w_left_keep[gi] = w_keep[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_right[gi] = w_entry[gi];
            end else begin : g_inner
                assign w_right[gi] = w_entry[gi+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occupied  (w_occupied[gi]),
                .i_left      (w_left[gi]),
                .i_left_keep (w_left_keep[gi]),
                .i_right     (w_right[gi]),
                .o_entry     (w_entry[gi]),
                .o_keep      (w_keep[gi])
            );
        end
    endgenerate

    always_comb begin
        n_occupancy = r_occupancy;
        if (w_ctl.put) begin
            n_occupancy = r_occupancy + OCC_W'(1);
        end else if (w_ctl.get) begin
            n_occupancy = r_occupancy - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occupancy <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_occupancy <= n_occupancy;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // result payload: head entry on a successful get, zeros otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id    <= '0;
            r_level <= '0;
            if (i_req.action == spq_pkg::ACT_PUT) begin
                r_status <= w_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
            end else if (w_empty) begin
                r_status <= spq_pkg::ST_EMPTY;
            end else begin
                r_status <= spq_pkg::ST_OK;
                r_id     <= w_entry[0].id;
                r_level  <= w_entry[0].level;
            end
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.out_packet_id = r_id;
    assign o_rsp.out_priority  = r_level;

endmodule
